// ===== design/lob_pkg.sv =====
package lob_pkg;

   localparam int AMOUNT_W = 42;

   typedef enum logic [1:0] {
      OP_ADD    = 2'd0,
      OP_CANCEL = 2'd1,
      OP_MATCH  = 2'd2,
      OP_QUERY  = 2'd3
   } op_type;

   typedef enum logic [1:0] {
      KIND_TRADE  = 2'd0,
      KIND_DONE   = 2'd1,
      KIND_REPORT = 2'd2
   } kind_type;

   typedef enum logic [1:0] {
      STAT_OK   = 2'd0,
      STAT_MISS = 2'd1,
      STAT_FULL = 2'd2
   } status_type;

   typedef enum logic [4:0] {
      S_CLEAR,
      S_IDLE,
      S_ADD0,
      S_ADD1,
      S_ADD2,
      S_QUERY,
      S_REPORT,
      S_M0,
      S_M1,
      S_M2,
      S_C1,
      S_C2,
      S_C3,
      S_C4,
      S_C5,
      S_C6,
      S_SCAN0,
      S_SCAN1,
      S_DONE
   } state_type;

   typedef struct packed {
      op_type        operation;
      logic [31:0]   order_id;
      logic          side;
      logic [7:0]    price;
      logic [31:0]   quantity;
      logic [63:0]   timestamp;
   } req_item_type;

   typedef struct packed {
      req_item_type  item;
      logic          price_ok;
   } cmd_type;

   typedef struct packed {
      kind_type              kind;
      logic [31:0]           resting_id;
      logic [31:0]           aggressor_id;
      logic                  aggressor_side;
      logic [7:0]            level_price;
      logic [AMOUNT_W-1:0]   amount;
      logic [63:0]           trade_time;
      logic [31:0]           remaining_qty;
      status_type            status;
      logic                  last;
   } rsp_item_type;

endpackage

// ===== design/lob_ram.sv =====
module lob_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 1024
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

// ===== design/lob_front.sv =====
module lob_front import lob_pkg::*; #(
   parameter int PRICE_LEVELS = 256,
   parameter int DEPTH = 4
) (
   input  logic         clock,
   input  logic         reset,
   input  logic         push,
   output logic         full,
   input  req_item_type item,
   input  logic         hold,
   output logic         cmd_valid,
   input  logic         cmd_pop,
   output cmd_type      cmd
);

   localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;

   cmd_type       mem_ff [DEPTH];
   logic [AW-1:0] wp_ff, wp_in, rp_ff, rp_in;
   logic [AW:0]   cnt_ff, cnt_in;
   logic          wr, rd;
   cmd_type       word;

   always_comb begin
      word.item = item;
      // out-of-range price is flagged here so the engine only reads one bit
      word.price_ok = (32'(item.price) < PRICE_LEVELS);
   end

   assign full = (cnt_ff == (AW+1)'(DEPTH)) || hold;
   assign cmd_valid = (cnt_ff != '0);
   assign cmd = mem_ff[rp_ff];
   assign wr = push && !full;
   assign rd = cmd_pop && cmd_valid;

   always_comb begin
      wp_in = wp_ff;
      rp_in = rp_ff;
      cnt_in = cnt_ff;
      if (wr) begin
         wp_in = (wp_ff == AW'(DEPTH-1)) ? '0 : wp_ff + 1'b1;
      end
      if (rd) begin
         rp_in = (rp_ff == AW'(DEPTH-1)) ? '0 : rp_ff + 1'b1;
      end
      if (wr && !rd) begin
         cnt_in = cnt_ff + 1'b1;
      end else if (rd && !wr) begin
         cnt_in = cnt_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wp_ff <= '0;
         rp_ff <= '0;
         cnt_ff <= '0;
      end else begin
         wp_ff <= wp_in;
         rp_ff <= rp_in;
         cnt_ff <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      if (wr) begin
         mem_ff[wp_ff] <= word;
      end
   end

endmodule

// ===== design/lob_rsp_queue.sv =====
module lob_rsp_queue import lob_pkg::*; #(
   parameter int DEPTH = 4
) (
   input  logic         clock,
   input  logic         reset,
   input  logic         wr_en,
   input  rsp_item_type wr_data,
   output logic         wr_full,
   output logic         empty,
   input  logic         pop,
   output rsp_item_type rd_data
);

   localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;

   rsp_item_type  mem_ff [DEPTH];
   logic [AW-1:0] wp_ff, wp_in, rp_ff, rp_in;
   logic [AW:0]   cnt_ff, cnt_in;
   logic          wr, rd;

   assign wr_full = (cnt_ff == (AW+1)'(DEPTH));
   assign empty = (cnt_ff == '0);
   assign rd_data = mem_ff[rp_ff];
   assign wr = wr_en && !wr_full;
   assign rd = pop && !empty;

   always_comb begin
      wp_in = wp_ff;
      rp_in = rp_ff;
      cnt_in = cnt_ff;
      if (wr) begin
         wp_in = (wp_ff == AW'(DEPTH-1)) ? '0 : wp_ff + 1'b1;
      end
      if (rd) begin
         rp_in = (rp_ff == AW'(DEPTH-1)) ? '0 : rp_ff + 1'b1;
      end
      if (wr && !rd) begin
         cnt_in = cnt_ff + 1'b1;
      end else if (rd && !wr) begin
         cnt_in = cnt_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wp_ff <= '0;
         rp_ff <= '0;
         cnt_ff <= '0;
      end else begin
         wp_ff <= wp_in;
         rp_ff <= rp_in;
         cnt_ff <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      if (wr) begin
         mem_ff[wp_ff] <= wr_data;
      end
   end

endmodule

// ===== design/lob_engine.sv =====
module lob_engine import lob_pkg::*; #(
   parameter int PRICE_LEVELS = 256,
   parameter int MAX_ORDERS = 1024,
   parameter int MAX_FILLS = 63
) (
   input  logic         clock,
   input  logic         reset,
   output logic         hold,
   input  logic         cmd_valid,
   output logic         cmd_pop,
   input  cmd_type      cmd,
   output logic         rsp_push,
   output rsp_item_type rsp_data,
   input  logic         rsp_full
);

   localparam int SW = $clog2(MAX_ORDERS);
   localparam int PW = $clog2(PRICE_LEVELS);
   localparam int LW = PW + 1;
   localparam int LDEPTH = 2 ** LW;
   localparam int MW = PW + 2;
   localparam int FW = $clog2(MAX_FILLS + 1);
   localparam int CLR_N = (MAX_ORDERS > LDEPTH) ? MAX_ORDERS : LDEPTH;
   localparam int CW = $clog2(CLR_N);
   localparam logic [SW:0] NIL = (SW+1)'(MAX_ORDERS);
   localparam logic [LW-1:0] NONE = LW'(PRICE_LEVELS);

   state_type        state_ff, state_in;
   logic [CW-1:0]    clr_ff, clr_in;
   logic [SW:0]      fc_ff, fc_in;
   logic [LW-1:0]    bid_ff, bid_in, ask_ff, ask_in;
   op_type           op_ff, op_in;
   logic [31:0]      id_ff, id_in;
   logic             side_ff, side_in;
   logic [7:0]       price_ff, price_in;
   logic             pok_ff, pok_in;
   logic [63:0]      time_ff, time_in;
   logic [31:0]      rem_ff, rem_in;
   status_type       status_ff, status_in;
   logic [FW-1:0]    nf_ff, nf_in;
   logic [LW-1:0]    lv_ff, lv_in;
   logic [SW-1:0]    sa_ff, sa_in;
   logic [PW-1:0]    lp_ff, lp_in;
   logic [SW-1:0]    head_ff, head_in;
   logic [SW:0]      lhead_ff, lhead_in;
   logic [SW-1:0]    tail_ff, tail_in;
   logic [SW-1:0]    tgt_ff, tgt_in;
   logic             tside_ff, tside_in;
   logic [31:0]      tq_ff, tq_in;
   logic [SW:0]      tnext_ff, tnext_in;
   logic [SW:0]      prev_ff, prev_in;
   logic             inlist_ff, inlist_in;
   logic             bhit_ff, bhit_in, ahit_ff, ahit_in;
   logic [SW-1:0]    bslot_ff, bslot_in, aslot_ff, aslot_in;
   logic             sd_ff, sd_in;
   logic [PW-1:0]    sp_ff, sp_in;

   logic                ids_we, qtys_we, next_we, meta_we, free_we;
   logic [SW-1:0]       ids_wa, qtys_wa, next_wa, meta_wa, free_wa;
   logic [31:0]         ids_wd, qtys_wd;
   logic [SW:0]         next_wd;
   logic [MW-1:0]       meta_wd;
   logic [SW-1:0]       free_wd;
   logic [31:0]         ids_rd, qtys_rd;
   logic [SW:0]         next_rd;
   logic [MW-1:0]       meta_rd;
   logic [SW-1:0]       free_rd;
   logic [SW-1:0]       free_ra;

   logic                heads_we, tails_we, tots_we;
   logic [LW-1:0]       heads_wa, tails_wa, tots_wa;
   logic [SW:0]         heads_wd;
   logic [SW-1:0]       tails_wd;
   logic [AMOUNT_W-1:0] tots_wd;
   logic [SW:0]         heads_rd;
   logic [SW-1:0]       tails_rd;
   logic [AMOUNT_W-1:0] tots_rd;

   logic [LW-1:0]       lp_pick;
   logic [31:0]         fill, left;
   logic                hit;

   assign hold = (state_ff == S_CLEAR);
   assign free_ra = SW'(fc_ff - 1'b1);

   // id, quantity, next and meta slot stores read at the next slot address, level stores at the next level
   lob_ram #(.WIDTH(32), .DEPTH(MAX_ORDERS)) u_ids (
      .clock(clock), .wr_en(ids_we), .wr_addr(ids_wa), .wr_data(ids_wd),
      .rd_addr(sa_in), .rd_data(ids_rd));
   lob_ram #(.WIDTH(32), .DEPTH(MAX_ORDERS)) u_qtys (
      .clock(clock), .wr_en(qtys_we), .wr_addr(qtys_wa), .wr_data(qtys_wd),
      .rd_addr(sa_in), .rd_data(qtys_rd));
   lob_ram #(.WIDTH(SW+1), .DEPTH(MAX_ORDERS)) u_next (
      .clock(clock), .wr_en(next_we), .wr_addr(next_wa), .wr_data(next_wd),
      .rd_addr(sa_in), .rd_data(next_rd));
   lob_ram #(.WIDTH(MW), .DEPTH(MAX_ORDERS)) u_meta (
      .clock(clock), .wr_en(meta_we), .wr_addr(meta_wa), .wr_data(meta_wd),
      .rd_addr(sa_in), .rd_data(meta_rd));
   lob_ram #(.WIDTH(SW), .DEPTH(MAX_ORDERS)) u_free (
      .clock(clock), .wr_en(free_we), .wr_addr(free_wa), .wr_data(free_wd),
      .rd_addr(free_ra), .rd_data(free_rd));
   lob_ram #(.WIDTH(SW+1), .DEPTH(LDEPTH)) u_heads (
      .clock(clock), .wr_en(heads_we), .wr_addr(heads_wa), .wr_data(heads_wd),
      .rd_addr(lv_in), .rd_data(heads_rd));
   lob_ram #(.WIDTH(SW), .DEPTH(LDEPTH)) u_tails (
      .clock(clock), .wr_en(tails_we), .wr_addr(tails_wa), .wr_data(tails_wd),
      .rd_addr(lv_in), .rd_data(tails_rd));
   lob_ram #(.WIDTH(AMOUNT_W), .DEPTH(LDEPTH)) u_tots (
      .clock(clock), .wr_en(tots_we), .wr_addr(tots_wa), .wr_data(tots_wd),
      .rd_addr(lv_in), .rd_data(tots_rd));

   always_comb begin
      state_in = state_ff;
      clr_in = clr_ff;
      fc_in = fc_ff;
      bid_in = bid_ff;
      ask_in = ask_ff;
      op_in = op_ff;
      id_in = id_ff;
      side_in = side_ff;
      price_in = price_ff;
      pok_in = pok_ff;
      time_in = time_ff;
      rem_in = rem_ff;
      status_in = status_ff;
      nf_in = nf_ff;
      lv_in = lv_ff;
      sa_in = sa_ff;
      lp_in = lp_ff;
      head_in = head_ff;
      lhead_in = lhead_ff;
      tail_in = tail_ff;
      tgt_in = tgt_ff;
      tside_in = tside_ff;
      tq_in = tq_ff;
      tnext_in = tnext_ff;
      prev_in = prev_ff;
      inlist_in = inlist_ff;
      bhit_in = bhit_ff;
      ahit_in = ahit_ff;
      bslot_in = bslot_ff;
      aslot_in = aslot_ff;
      sd_in = sd_ff;
      sp_in = sp_ff;

      ids_we = 1'b0;   ids_wa = '0;   ids_wd = '0;
      qtys_we = 1'b0;  qtys_wa = '0;  qtys_wd = '0;
      next_we = 1'b0;  next_wa = '0;  next_wd = '0;
      meta_we = 1'b0;  meta_wa = '0;  meta_wd = '0;
      free_we = 1'b0;  free_wa = '0;  free_wd = '0;
      heads_we = 1'b0; heads_wa = '0; heads_wd = '0;
      tails_we = 1'b0; tails_wa = '0; tails_wd = '0;
      tots_we = 1'b0;  tots_wa = '0;  tots_wd = '0;

      cmd_pop = 1'b0;
      rsp_push = 1'b0;
      rsp_data = '0;
      rsp_data.aggressor_id = id_ff;
      rsp_data.aggressor_side = side_ff;
      rsp_data.trade_time = time_ff;

      lp_pick = '0;
      fill = (rem_ff < qtys_rd) ? rem_ff : qtys_rd;
      left = qtys_rd - fill;
      hit = 1'b0;

      case (state_ff)
         S_CLEAR: begin
            if (32'(clr_ff) < MAX_ORDERS) begin
               meta_we = 1'b1;
               meta_wa = SW'(clr_ff);
               meta_wd = '0;
               free_we = 1'b1;
               free_wa = SW'(clr_ff);
               free_wd = SW'(MAX_ORDERS - 1 - 32'(clr_ff));
            end
            if (32'(clr_ff) < LDEPTH) begin
               heads_we = 1'b1;
               heads_wa = LW'(clr_ff);
               heads_wd = NIL;
               tots_we = 1'b1;
               tots_wa = LW'(clr_ff);
               tots_wd = '0;
            end
            clr_in = clr_ff + 1'b1;
            if (clr_ff == CW'(CLR_N - 1)) begin
               state_in = S_IDLE;
            end
         end

         S_IDLE: begin
            if (cmd_valid) begin
               cmd_pop = 1'b1;
               op_in = cmd.item.operation;
               id_in = cmd.item.order_id;
               side_in = cmd.item.side;
               price_in = cmd.item.price;
               pok_in = cmd.price_ok;
               time_in = cmd.item.timestamp;
               rem_in = cmd.item.quantity;
               status_in = STAT_OK;
               nf_in = '0;
               case (cmd.item.operation)
                  OP_ADD: state_in = S_ADD0;
                  OP_CANCEL: begin
                     sa_in = '0;
                     bhit_in = 1'b0;
                     ahit_in = 1'b0;
                     state_in = S_C1;
                  end
                  OP_MATCH: state_in = S_M0;
                  OP_QUERY: state_in = S_QUERY;
                  default: state_in = S_IDLE;
               endcase
            end
         end

         S_ADD0: begin
            if (!pok_ff) begin
               status_in = STAT_MISS;
               state_in = S_DONE;
            end else if (fc_ff == '0) begin
               status_in = STAT_FULL;
               state_in = S_DONE;
            end else begin
               lp_in = PW'(price_ff);
               lv_in = {side_ff, PW'(price_ff)};
               state_in = S_ADD1;
            end
         end

         S_ADD1: begin
            ids_we = 1'b1;  ids_wa = free_rd;  ids_wd = id_ff;
            qtys_we = 1'b1; qtys_wa = free_rd; qtys_wd = rem_ff;
            next_we = 1'b1; next_wa = free_rd; next_wd = NIL;
            meta_we = 1'b1; meta_wa = free_rd; meta_wd = {1'b1, side_ff, lp_ff};
            tails_we = 1'b1; tails_wa = lv_ff; tails_wd = free_rd;
            tots_we = 1'b1; tots_wa = lv_ff; tots_wd = tots_rd + AMOUNT_W'(rem_ff);
            fc_in = fc_ff - 1'b1;
            tgt_in = free_rd;
            lhead_in = heads_rd;
            tail_in = tails_rd;
            state_in = S_ADD2;
         end

         S_ADD2: begin
            if (lhead_ff == NIL) begin
               heads_we = 1'b1;
               heads_wa = lv_ff;
               heads_wd = {1'b0, tgt_ff};
            end else begin
               next_we = 1'b1;
               next_wa = tail_ff;
               next_wd = {1'b0, tgt_ff};
            end
            if (!side_ff) begin
               if (bid_ff == NONE || {1'b0, lp_ff} > bid_ff) begin
                  bid_in = {1'b0, lp_ff};
               end
            end else if ({1'b0, lp_ff} < ask_ff) begin
               ask_in = {1'b0, lp_ff};
            end
            status_in = STAT_OK;
            state_in = S_DONE;
         end

         S_QUERY: begin
            lp_pick = side_ff ? ask_ff : bid_ff;
            if (lp_pick == NONE) begin
               status_in = STAT_MISS;
            end else begin
               status_in = STAT_OK;
               lp_in = lp_pick[PW-1:0];
               lv_in = {side_ff, lp_pick[PW-1:0]};
            end
            state_in = S_REPORT;
         end

         S_REPORT: begin
            if (!rsp_full) begin
               rsp_push = 1'b1;
               rsp_data.kind = KIND_REPORT;
               rsp_data.status = status_ff;
               rsp_data.last = 1'b1;
               if (status_ff == STAT_OK) begin
                  rsp_data.level_price = 8'(lp_ff);
                  rsp_data.amount = tots_rd;
               end
               state_in = S_IDLE;
            end
         end

         S_M0: begin
            // a buy takes asks, a sell takes bids
            lp_pick = side_ff ? bid_ff : ask_ff;
            if (rem_ff == '0 || nf_ff == FW'(MAX_FILLS) || lp_pick == NONE) begin
               state_in = S_DONE;
            end else if (!side_ff ? (32'(price_ff) < 32'(lp_pick))
                                  : (32'(price_ff) > 32'(lp_pick))) begin
               state_in = S_DONE;
            end else begin
               lp_in = lp_pick[PW-1:0];
               lv_in = {~side_ff, lp_pick[PW-1:0]};
               state_in = S_M1;
            end
         end

         S_M1: begin
            if (heads_rd == NIL) begin
               state_in = S_DONE;
            end else begin
               head_in = SW'(heads_rd);
               sa_in = SW'(heads_rd);
               state_in = S_M2;
            end
         end

         S_M2: begin
            if (!rsp_full) begin
               rsp_push = 1'b1;
               rsp_data.kind = KIND_TRADE;
               rsp_data.resting_id = ids_rd;
               rsp_data.level_price = 8'(lp_ff);
               rsp_data.amount = AMOUNT_W'(fill);
               rsp_data.status = STAT_OK;
               rem_in = rem_ff - fill;
               nf_in = nf_ff + 1'b1;
               qtys_we = 1'b1; qtys_wa = head_ff; qtys_wd = left;
               tots_we = 1'b1; tots_wa = lv_ff; tots_wd = tots_rd - AMOUNT_W'(fill);
               state_in = S_M0;
               if (left == '0) begin
                  // filled resting order leaves from the front of its level
                  heads_we = 1'b1; heads_wa = lv_ff; heads_wd = next_rd;
                  meta_we = 1'b1;  meta_wa = head_ff; meta_wd = '0;
                  free_we = 1'b1;  free_wa = SW'(fc_ff); free_wd = head_ff;
                  fc_in = fc_ff + 1'b1;
                  if (next_rd == NIL) begin
                     sd_in = ~side_ff;
                     sp_in = lp_ff;
                     state_in = S_SCAN0;
                  end
               end
            end
         end

         S_SCAN0: begin
            // bids search downward, asks upward, for the next non-empty level
            if (!sd_ff && sp_ff == '0) begin
               bid_in = NONE;
               state_in = (op_ff == OP_MATCH) ? S_M0 : S_DONE;
            end else if (sd_ff && sp_ff == PW'(PRICE_LEVELS - 1)) begin
               ask_in = NONE;
               state_in = (op_ff == OP_MATCH) ? S_M0 : S_DONE;
            end else begin
               sp_in = sd_ff ? sp_ff + 1'b1 : sp_ff - 1'b1;
               lv_in = {sd_ff, sp_in};
               state_in = S_SCAN1;
            end
         end

         S_SCAN1: begin
            if (heads_rd != NIL) begin
               if (sd_ff) begin
                  ask_in = {1'b0, sp_ff};
               end else begin
                  bid_in = {1'b0, sp_ff};
               end
               state_in = (op_ff == OP_MATCH) ? S_M0 : S_DONE;
            end else begin
               state_in = S_SCAN0;
            end
         end

         S_C1: begin
            hit = meta_rd[MW-1] && (ids_rd == id_ff);
            if (hit && !meta_rd[PW] && !bhit_ff) begin
               bhit_in = 1'b1;
               bslot_in = sa_ff;
            end
            if (hit && meta_rd[PW] && !ahit_ff) begin
               ahit_in = 1'b1;
               aslot_in = sa_ff;
            end
            if (sa_ff == SW'(MAX_ORDERS - 1)) begin
               state_in = S_C2;
            end else begin
               sa_in = sa_ff + 1'b1;
            end
         end

         S_C2: begin
            if (bhit_ff) begin
               tgt_in = bslot_ff;
               sa_in = bslot_ff;
               state_in = S_C3;
            end else if (ahit_ff) begin
               tgt_in = aslot_ff;
               sa_in = aslot_ff;
               state_in = S_C3;
            end else begin
               status_in = STAT_MISS;
               state_in = S_DONE;
            end
         end

         S_C3: begin
            tside_in = meta_rd[PW];
            lp_in = meta_rd[PW-1:0];
            lv_in = {meta_rd[PW], meta_rd[PW-1:0]};
            tq_in = qtys_rd;
            tnext_in = next_rd;
            state_in = S_C4;
         end

         S_C4: begin
            prev_in = NIL;
            if (heads_rd == {1'b0, tgt_ff}) begin
               inlist_in = 1'b1;
               state_in = S_C6;
            end else if (heads_rd == NIL) begin
               inlist_in = 1'b0;
               state_in = S_C6;
            end else begin
               prev_in = heads_rd;
               sa_in = SW'(heads_rd);
               state_in = S_C5;
            end
         end

         S_C5: begin
            if (next_rd == {1'b0, tgt_ff}) begin
               inlist_in = 1'b1;
               state_in = S_C6;
            end else if (next_rd == NIL) begin
               inlist_in = 1'b0;
               state_in = S_C6;
            end else begin
               prev_in = next_rd;
               sa_in = SW'(next_rd);
            end
         end

         S_C6: begin
            status_in = STAT_OK;
            state_in = S_DONE;
            meta_we = 1'b1; meta_wa = tgt_ff; meta_wd = '0;
            free_we = 1'b1; free_wa = SW'(fc_ff); free_wd = tgt_ff;
            fc_in = fc_ff + 1'b1;
            if (inlist_ff) begin
               if (prev_ff == NIL) begin
                  heads_we = 1'b1; heads_wa = lv_ff; heads_wd = tnext_ff;
               end else begin
                  next_we = 1'b1; next_wa = SW'(prev_ff); next_wd = tnext_ff;
               end
               if (tails_rd == tgt_ff) begin
                  tails_we = 1'b1; tails_wa = lv_ff; tails_wd = SW'(prev_ff);
               end
               tots_we = 1'b1; tots_wa = lv_ff; tots_wd = tots_rd - AMOUNT_W'(tq_ff);
               // level emptied while it was the best one
               if (prev_ff == NIL && tnext_ff == NIL &&
                   (tside_ff ? ask_ff : bid_ff) == {1'b0, lp_ff}) begin
                  sd_in = tside_ff;
                  sp_in = lp_ff;
                  state_in = S_SCAN0;
               end
            end
         end

         S_DONE: begin
            if (!rsp_full) begin
               rsp_push = 1'b1;
               rsp_data.kind = KIND_DONE;
               rsp_data.remaining_qty = (op_ff == OP_MATCH) ? rem_ff : '0;
               rsp_data.status = status_ff;
               rsp_data.last = 1'b1;
               state_in = S_IDLE;
            end
         end

         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_CLEAR;
         clr_ff <= '0;
         fc_ff <= (SW+1)'(MAX_ORDERS);
         bid_ff <= NONE;
         ask_ff <= NONE;
      end else begin
         state_ff <= state_in;
         clr_ff <= clr_in;
         fc_ff <= fc_in;
         bid_ff <= bid_in;
         ask_ff <= ask_in;
      end
   end

   always_ff @(posedge clock) begin
      op_ff <= op_in;
      id_ff <= id_in;
      side_ff <= side_in;
      price_ff <= price_in;
      pok_ff <= pok_in;
      time_ff <= time_in;
      rem_ff <= rem_in;
      status_ff <= status_in;
      nf_ff <= nf_in;
      lv_ff <= lv_in;
      sa_ff <= sa_in;
      lp_ff <= lp_in;
      head_ff <= head_in;
      lhead_ff <= lhead_in;
      tail_ff <= tail_in;
      tgt_ff <= tgt_in;
      tside_ff <= tside_in;
      tq_ff <= tq_in;
      tnext_ff <= tnext_in;
      prev_ff <= prev_in;
      inlist_ff <= inlist_in;
      bhit_ff <= bhit_in;
      ahit_ff <= ahit_in;
      bslot_ff <= bslot_in;
      aslot_ff <= aslot_in;
      sd_ff <= sd_in;
      sp_ff <= sp_in;
   end

endmodule

// ===== design/limit_order_book_matcher.sv =====
// channel  direction  handshake                 payload
// req      in         push / full               req_operation .. req_timestamp
// rsp      out        empty / pop               rsp_kind .. rsp_symbol
// csr      in         csr_valid / csr_ready     csr_symbol_code
//
// after reset a clearing pass over every slot and level entry
// runs with full held high; csr writes are taken during it.
// a match fills against resting orders level by level and steps over empty levels
// when a level empties; cancel scans every slot once, then walks
// the level list one slot per cycle.
// a full result queue stalls the engine; a four-word input queue absorbs bursts.
module limit_order_book_matcher import lob_pkg::*; #(
   parameter int PRICE_LEVELS = 256,
   parameter int MAX_ORDERS = 1024,
   parameter int MAX_FILLS = 63
) (
   input  logic                clock,
   input  logic                reset,
   input  logic                push,
   output logic                full,
   input  logic [1:0]          req_operation,
   input  logic [31:0]         req_order_id,
   input  logic                req_side,
   input  logic [7:0]          req_price,
   input  logic [31:0]         req_quantity,
   input  logic [63:0]         req_timestamp,
   output logic                empty,
   input  logic                pop,
   output logic [1:0]          rsp_kind,
   output logic [31:0]         rsp_resting_id,
   output logic [31:0]         rsp_aggressor_id,
   output logic                rsp_aggressor_side,
   output logic [7:0]          rsp_level_price,
   output logic [AMOUNT_W-1:0] rsp_amount,
   output logic [63:0]         rsp_trade_time,
   output logic [31:0]         rsp_remaining_qty,
   output logic [1:0]          rsp_status,
   output logic                rsp_last,
   output logic [15:0]         rsp_symbol,
   input  logic                csr_valid,
   output logic                csr_ready,
   input  logic [15:0]         csr_symbol_code
);

   logic [15:0]  symbol_ff;
   req_item_type req_word;
   cmd_type      cmd;
   logic         cmd_valid, cmd_pop, hold;
   logic         eng_push, eng_full;
   rsp_item_type eng_word, rsp_word;

   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         symbol_ff <= '0;
      end else if (csr_valid && csr_ready) begin
         symbol_ff <= csr_symbol_code;
      end
   end

   always_comb begin
      req_word.operation = op_type'(req_operation);
      req_word.order_id = req_order_id;
      req_word.side = req_side;
      req_word.price = req_price;
      req_word.quantity = req_quantity;
      req_word.timestamp = req_timestamp;
   end

   lob_front #(.PRICE_LEVELS(PRICE_LEVELS), .DEPTH(4)) u_front (
      .clock(clock), .reset(reset), .push(push), .full(full), .item(req_word),
      .hold(hold), .cmd_valid(cmd_valid), .cmd_pop(cmd_pop), .cmd(cmd));

   lob_engine #(
      .PRICE_LEVELS(PRICE_LEVELS), .MAX_ORDERS(MAX_ORDERS), .MAX_FILLS(MAX_FILLS)
   ) u_engine (
      .clock(clock), .reset(reset), .hold(hold), .cmd_valid(cmd_valid),
      .cmd_pop(cmd_pop), .cmd(cmd), .rsp_push(eng_push), .rsp_data(eng_word),
      .rsp_full(eng_full));

   lob_rsp_queue #(.DEPTH(4)) u_rsp_queue (
      .clock(clock), .reset(reset), .wr_en(eng_push), .wr_data(eng_word),
      .wr_full(eng_full), .empty(empty), .pop(pop), .rd_data(rsp_word));

   assign rsp_kind = rsp_word.kind;
   assign rsp_resting_id = rsp_word.resting_id;
   assign rsp_aggressor_id = rsp_word.aggressor_id;
   assign rsp_aggressor_side = rsp_word.aggressor_side;
   assign rsp_level_price = rsp_word.level_price;
   assign rsp_amount = rsp_word.amount;
   assign rsp_trade_time = rsp_word.trade_time;
   assign rsp_remaining_qty = rsp_word.remaining_qty;
   assign rsp_status = rsp_word.status;
   assign rsp_last = rsp_word.last;
   // the user must keep configuration changes to while idle; the block does not enforce it
   assign rsp_symbol = symbol_ff;

endmodule

// ===== design/lob_checker.sv =====
module lob_checker import lob_pkg::*; (
   input logic                clock,
   input logic                reset,
   input logic                full,
   input logic                empty,
   input logic                pop,
   input logic [1:0]          rsp_kind,
   input logic [AMOUNT_W-1:0] rsp_amount,
   input logic [1:0]          rsp_status,
   input logic                rsp_last
);

   // clearing pass blocks input and nothing is waiting after reset
   a_reset_quiet: assert property (@(posedge clock)
      reset |=> full && empty)
      else $error("input open or result waiting right after reset");

   a_hold_word: assert property (@(posedge clock) disable iff (reset)
      !empty && !pop |=> !empty && $stable(rsp_kind) && $stable(rsp_amount))
      else $error("stalled result word changed");

   a_trade_not_last: assert property (@(posedge clock) disable iff (reset)
      !empty && rsp_kind == KIND_TRADE |-> !rsp_last && rsp_status == STAT_OK)
      else $error("trade closed a run or carried an error");

   a_single_last: assert property (@(posedge clock) disable iff (reset)
      !empty && (rsp_kind == KIND_DONE || rsp_kind == KIND_REPORT) |-> rsp_last)
      else $error("completion or report without last");

   a_miss_zero: assert property (@(posedge clock) disable iff (reset)
      !empty && rsp_kind == KIND_REPORT && rsp_status == STAT_MISS |-> rsp_amount == '0)
      else $error("empty side report with nonzero amount");

endmodule

bind limit_order_book_matcher lob_checker u_lob_checker (.*);
